### rtl/hcr_pkg.sv
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared widths, register map, config record and divider step for the
// height colour ramp.
// ----------------------------------------------------------------------------
package hcr_pkg;

  localparam int HB = 32;                 // height width, signed fixed point
  localparam int WF = 16;                 // weight fraction bits
  localparam int DW = HB + 1;             // divider remainder/divisor width
  localparam int SPLIT_STEPS = WF + 8;    // quotient bits of the split ratio
  localparam int MW = WF + 10;            // signed split ratio width
  localparam int SW = WF + 12;            // signed weight work width
  localparam int WW = WF + 9;             // clamped weight width, 0..256.0
  localparam int PW = WW + 9 - WF;        // rounded channel product width
  localparam int AW = 5;                  // config byte address width

  localparam logic [2:0] REG_FROM  = 3'd0;
  localparam logic [2:0] REG_TO    = 3'd1;
  localparam logic [2:0] REG_LOW   = 3'd2;
  localparam logic [2:0] REG_HIGH  = 3'd3;
  localparam logic [2:0] REG_MODE  = 3'd4;

  localparam logic [31:0] RST_FROM = 32'd0;
  localparam logic [31:0] RST_TO   = 32'd65536;
  localparam logic [31:0] RST_LOW  = 32'hFF0000FF;
  localparam logic [31:0] RST_HIGH = 32'hFFFF00FF;
  localparam logic [2:0]  RST_MODE = 3'd2;

  typedef struct packed {
    logic [HB-1:0] range_from;
    logic [HB-1:0] range_to;
    logic [31:0]   low_colour;
    logic [31:0]   high_colour;
    logic [2:0]    ramp_mode;
  } cfg_t;

  // One restoring step: shift in a bit, subtract when the divisor fits.
  // Returns {quotient bit, new remainder}.
  function automatic logic [DW:0] div_step(logic [DW-1:0] rem, logic bin,
                                           logic [DW-1:0] dv);
    logic [DW:0] t;
    logic [DW:0] d;
    t = {rem, bin};
    d = {1'b0, dv};
    if (t >= d) begin
      t = t - d;
      return {1'b1, t[DW-1:0]};
    end
    return {1'b0, t[DW-1:0]};
  endfunction

endpackage

### rtl/hcr_core.sv
// ----------------------------------------------------------------------------
// hcr_core
// Pipelined datapath: modulo, split ratio and span divisions, phase division,
// quadratic weight division, squaring, weight select, channel products and sum.
// ----------------------------------------------------------------------------
module hcr_core
  import hcr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [HB-1:0]       in_z,
  input  cfg_t                cfg,
  output logic                out_valid,
  output logic [3:0][7:0]     out_rgba   // [0] red, [1] green, [2] blue, [3] alpha
);

  localparam logic [1:0] NC_ZERO = 2'd0;
  localparam logic [1:0] NC_ONE  = 2'd1;
  localparam logic [1:0] NC_DIV  = 2'd2;

  localparam int NST = HB + 2 * WF + 7;

  localparam logic signed [SW-1:0] ONE_S  = SW'(1) <<< WF;
  localparam logic signed [SW-1:0] WLIM_S = SW'(1) <<< (WF + 8);
  localparam logic [MW-1:0]        WLIM_M = MW'(1) << (WF + 8);
  localparam logic [WF:0]          HALF_U = (WF+1)'(1) << (WF - 1);
  localparam logic [8+WW:0]        HALF_P = (9+WW)'(1) << (WF - 1);

  typedef struct packed {
    logic [2:0]               mode;
    logic [31:0]              lo;
    logic [31:0]              hi;
    logic                     s_zero;
    logic [DW-1:0]            sm;
    logic [DW-1:0]            md_rem;
    logic [HB-1:0]            md_qd;
    logic                     zneg;
    logic [DW-1:0]            sp_rem;
    logic [SPLIT_STEPS-1:0]   sp_qd;
    logic                     sp_sat;
    logic                     sp_neg;
    logic [DW-1:0]            nc_div;
    logic [DW-1:0]            nc_rem;
    logic [WF-1:0]            nc_q;
    logic [1:0]               nc_kind;
  } a_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic [31:0]              lo;
    logic [31:0]              hi;
    logic                     s_zero;
    logic signed [MW-1:0]     m;
    logic [WF:0]              vnc;
    logic [DW-1:0]            sm;
    logic [DW-1:0]            v_rem;
    logic [WF-1:0]            v_q;
  } b_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic [31:0]              lo;
    logic [31:0]              hi;
    logic [WF:0]              v;
    logic signed [MW-1:0]     m;
    logic [DW-1:0]            q_div;
    logic [DW-1:0]            q_rem;
    logic [WF-1:0]            q_q;
  } c_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic [31:0]              lo;
    logic [31:0]              hi;
    logic [WF:0]              v;
    logic signed [MW-1:0]     m;
    logic [WF:0]              w;
  } sq_t;

  typedef struct packed {
    logic [3:0][7:0]          col_a;
    logic [3:0][7:0]          col_b;
    logic [WW-1:0]            wa;
    logic [WW-1:0]            wb;
  } wt_t;

  function automatic logic [3:0][7:0] bytes_of(logic [31:0] c);
    logic [3:0][7:0] r;
    for (int k = 0; k < 4; k++) begin
      r[k] = c[31-8*k -: 8];
    end
    return r;
  endfunction

  function automatic logic [WW-1:0] wclamp(logic signed [SW-1:0] w);
    if (w > WLIM_S) begin
      return WLIM_S[WW-1:0];
    end
    if (w <= 0) begin
      return '0;
    end
    return w[WW-1:0];
  endfunction

  logic [NST-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[NST-1];

  // --------------------------------------------------------------- entry
  a_t a_r [0:HB];
  a_t a_in;

  always_comb begin
    logic signed [HB+1:0] z_x, fr_x, to_x, d_x, n_x, s_x, sm_x, zz_x, za_x, fa_x;
    logic [HB-1:0] fa;
    logic sneg;
    z_x  = (HB+2)'($signed(in_z));
    fr_x = (HB+2)'($signed(cfg.range_from));
    to_x = (HB+2)'($signed(cfg.range_to));
    d_x  = to_x - fr_x;
    n_x  = z_x - fr_x;
    if (d_x < 0) begin
      d_x = -d_x;
      n_x = -n_x;
    end
    s_x  = fr_x + to_x;
    sneg = s_x < 0;
    sm_x = sneg ? -s_x : s_x;
    zz_x = sneg ? -z_x : z_x;
    za_x = (zz_x < 0) ? -zz_x : zz_x;
    fa_x = (fr_x < 0) ? -fr_x : fr_x;
    fa   = fa_x[HB-1:0];

    a_in.mode    = cfg.ramp_mode;
    a_in.lo      = cfg.low_colour;
    a_in.hi      = cfg.high_colour;
    a_in.s_zero  = (s_x == 0);
    a_in.sm      = sm_x[HB:0];
    a_in.md_rem  = '0;
    a_in.md_qd   = za_x[HB-1:0];
    a_in.zneg    = zz_x < 0;
    a_in.sp_rem  = DW'(fa >> 8);
    a_in.sp_qd   = {fa[7:0], {WF{1'b0}}};
    a_in.sp_sat  = {9'b0, fa} >= {sm_x[HB:0], 8'b0};
    a_in.sp_neg  = (fr_x < 0) ^ sneg;
    a_in.nc_div  = d_x[HB:0];
    a_in.nc_rem  = n_x[HB:0];
    a_in.nc_q    = '0;
    if (d_x == 0 || n_x <= 0) begin
      a_in.nc_kind = NC_ZERO;
    end else if (n_x >= d_x) begin
      a_in.nc_kind = NC_ONE;
    end else begin
      a_in.nc_kind = NC_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= a_in;
    end
  end

  // Phase A: height modulo period, split ratio and span fraction in parallel
  for (genvar k = 0; k < HB; k++) begin : g_a
    a_t nx;
    always_comb begin
      logic [DW:0] st;
      nx = a_r[k];
      st = div_step(a_r[k].md_rem, a_r[k].md_qd[HB-1], a_r[k].sm);
      nx.md_rem = st[DW-1:0];
      nx.md_qd  = a_r[k].md_qd << 1;
      if (k < SPLIT_STEPS) begin
        st = div_step(a_r[k].sp_rem, a_r[k].sp_qd[SPLIT_STEPS-1], a_r[k].sm);
        nx.sp_rem = st[DW-1:0];
        nx.sp_qd  = {a_r[k].sp_qd[SPLIT_STEPS-2:0], st[DW]};
      end
      if (k < WF) begin
        st = div_step(a_r[k].nc_rem, 1'b0, a_r[k].nc_div);
        nx.nc_rem = st[DW-1:0];
        nx.nc_q   = {a_r[k].nc_q[WF-2:0], st[DW]};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k+1] <= nx;
      end
    end
  end

  // --------------------------------------------------------------- phase B
  b_t b_r [0:WF];
  b_t b_in;

  always_comb begin
    a_t x;
    logic [DW-1:0] r;
    logic [MW-1:0] mag;
    x = a_r[HB];
    r = x.md_rem;
    if (x.zneg && r != 0) begin
      r = x.sm - r;
    end
    mag = x.sp_sat ? WLIM_M : MW'(x.sp_qd);
    b_in.mode   = x.mode;
    b_in.lo     = x.lo;
    b_in.hi     = x.hi;
    b_in.s_zero = x.s_zero;
    if (x.s_zero) begin
      b_in.m = '0;
    end else begin
      b_in.m = x.sp_neg ? -$signed(mag) : $signed(mag);
    end
    case (x.nc_kind)
      NC_ONE:  b_in.vnc = (WF+1)'(1) << WF;
      NC_DIV:  b_in.vnc = {1'b0, x.nc_q};
      default: b_in.vnc = '0;
    endcase
    b_in.sm    = x.sm;
    b_in.v_rem = r;
    b_in.v_q   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r[0] <= b_in;
    end
  end

  // Phase B: phase fraction of the period
  for (genvar k = 0; k < WF; k++) begin : g_b
    b_t nx;
    always_comb begin
      logic [DW:0] st;
      nx = b_r[k];
      st = div_step(b_r[k].v_rem, 1'b0, b_r[k].sm);
      nx.v_rem = st[DW-1:0];
      nx.v_q   = {b_r[k].v_q[WF-2:0], st[DW]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        b_r[k+1] <= nx;
      end
    end
  end

  // --------------------------------------------------------------- phase C
  c_t c_r [0:WF];
  c_t c_in;

  always_comb begin
    b_t x;
    logic [WF:0] v;
    logic signed [SW-1:0] vs, ms, qa, qb;
    logic band;
    x = b_r[WF];
    if (x.mode[0]) begin
      v = x.s_zero ? '0 : {1'b0, x.v_q};
    end else begin
      v = x.vnc;
    end
    vs   = $signed(SW'(v));
    ms   = SW'(x.m);
    band = vs < ms;
    qa   = band ? vs : vs - ms;
    qb   = band ? ms : ONE_S - ms;
    c_in.mode  = x.mode;
    c_in.lo    = x.lo;
    c_in.hi    = x.hi;
    c_in.v     = v;
    c_in.m     = x.m;
    c_in.q_rem = DW'(qa);
    c_in.q_div = DW'(qb);
    c_in.q_q   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0] <= c_in;
    end
  end

  // Phase C: position inside the band for the quadratic ramp
  for (genvar k = 0; k < WF; k++) begin : g_c
    c_t nx;
    always_comb begin
      logic [DW:0] st;
      nx = c_r[k];
      st = div_step(c_r[k].q_rem, 1'b0, c_r[k].q_div);
      nx.q_rem = st[DW-1:0];
      nx.q_q   = {c_r[k].q_q[WF-2:0], st[DW]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c_r[k+1] <= nx;
      end
    end
  end

  // --------------------------------------------------------------- square
  sq_t sq_r;

  always_ff @(posedge clk) begin
    logic signed [WF:0] u;
    logic signed [2*WF+1:0] p;
    if (en) begin
      u = $signed({1'b0, c_r[WF].q_q}) - $signed(HALF_U);
      p = u * u;
      sq_r.mode <= c_r[WF].mode;
      sq_r.lo   <= c_r[WF].lo;
      sq_r.hi   <= c_r[WF].hi;
      sq_r.v    <= c_r[WF].v;
      sq_r.m    <= c_r[WF].m;
      sq_r.w    <= p[2*WF-2:WF-2];
    end
  end

  // --------------------------------------------------------------- weights
  wt_t wt_r;
  wt_t wt_nxt;

  always_comb begin
    logic [3:0][7:0] lo, hi, av;
    logic signed [SW-1:0] vs, ms, ws, v2, t, wa, wb;
    lo = bytes_of(sq_r.lo);
    hi = bytes_of(sq_r.hi);
    for (int k = 0; k < 4; k++) begin
      av[k] = {1'b0, lo[k][7:1]} + {1'b0, hi[k][7:1]};
    end
    vs = $signed(SW'(sq_r.v));
    ms = SW'(sq_r.m);
    ws = $signed(SW'(sq_r.w));
    v2 = vs <<< 1;
    t  = '0;
    wt_nxt.col_a = lo;
    wt_nxt.col_b = hi;
    wa = vs;
    wb = ONE_S - vs;
    if (sq_r.mode[0]) begin
      if (sq_r.mode[2]) begin
        wa = (vs < ms) ? ONE_S : '0;
        wb = (vs < ms) ? '0 : ONE_S;
      end else if (sq_r.mode[1]) begin
        if (v2 < ms) begin
          wt_nxt.col_a = av;
          wt_nxt.col_b = lo;
          wa = ONE_S - vs;
          wb = vs;
        end else if (v2 < ONE_S + ms) begin
          t  = (v2 - ms) >>> 1;
          wa = ONE_S - t;
          wb = t;
        end else begin
          t  = (v2 - ONE_S - ms) >>> 1;
          wt_nxt.col_a = hi;
          wt_nxt.col_b = av;
          wa = ONE_S - t;
          wb = t;
        end
      end else begin
        if (vs < ms) begin
          wt_nxt.col_b = av;
          wa = ONE_S - ws;
          wb = ws;
        end else begin
          wt_nxt.col_a = av;
          wa = ws;
          wb = ONE_S - ws;
        end
      end
    end
    wt_nxt.wa = wclamp(wa);
    wt_nxt.wb = wclamp(wb);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wt_r <= wt_nxt;
    end
  end

  // --------------------------------------------------------------- products
  logic [3:0][PW-1:0] pa_r, pb_r;

  always_ff @(posedge clk) begin
    logic [8+WW:0] xa, xb;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        xa = (9+WW)'(wt_r.col_a[k] * wt_r.wa) + HALF_P;
        xb = (9+WW)'(wt_r.col_b[k] * wt_r.wb) + HALF_P;
        pa_r[k] <= xa[8+WW:WF];
        pb_r[k] <= xb[8+WW:WF];
      end
    end
  end

  // --------------------------------------------------------------- sum
  always_ff @(posedge clk) begin
    logic [7:0] ca, cb;
    logic [8:0] s;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ca = (pa_r[k] > PW'(255)) ? 8'hFF : pa_r[k][7:0];
        cb = (pb_r[k] > PW'(255)) ? 8'hFF : pb_r[k][7:0];
        s  = {1'b0, ca} + {1'b0, cb};
        out_rgba[k] <= s[8] ? 8'hFF : s[7:0];
      end
    end
  end

endmodule

### rtl/height_colour_ramp_top.sv
// Pipeline from input transfer to result valid: three entry registers, 32-step
//   modulo, 16-step phase division and 16-step band division, then four
//   stages: square, weight select, products, sum.
// Throughput: one height per cycle; the whole pipeline holds while a result
//   waits at the output.
// Reset: synchronous active-low rst_n clears all valid bits and loads the
//   config registers with their defaults.
// ----------------------------------------------------------------------------
// height_colour_ramp_top
// Height to RGBA colour ramp with APB config registers and stream ports.
// ----------------------------------------------------------------------------
module height_colour_ramp_top
  import hcr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,     // [31:0] height_z
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata,    // [7:0] red_out, [15:8] green_out,
                                      // [23:16] blue_out, [31:24] alpha_out
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [AW-1:0] cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  cfg_t cfg_r;
  logic [2:0] reg_idx;
  logic adv;
  logic [3:0][7:0] rgba;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_from  <= RST_FROM;
      cfg_r.range_to    <= RST_TO;
      cfg_r.low_colour  <= RST_LOW;
      cfg_r.high_colour <= RST_HIGH;
      cfg_r.ramp_mode   <= RST_MODE;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (reg_idx)
        REG_FROM: cfg_r.range_from  <= cfg_pwdata;
        REG_TO:   cfg_r.range_to    <= cfg_pwdata;
        REG_LOW:  cfg_r.low_colour  <= cfg_pwdata;
        REG_HIGH: cfg_r.high_colour <= cfg_pwdata;
        REG_MODE: cfg_r.ramp_mode   <= cfg_pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FROM: cfg_prdata = cfg_r.range_from;
      REG_TO:   cfg_prdata = cfg_r.range_to;
      REG_LOW:  cfg_prdata = cfg_r.low_colour;
      REG_HIGH: cfg_prdata = cfg_r.high_colour;
      REG_MODE: cfg_prdata = {29'b0, cfg_r.ramp_mode};
      default:  cfg_prdata = '0;
    endcase
  end

  // advance everything unless a result is held at the output
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign out_tdata = rgba;

  hcr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_tvalid),
    .in_z      (in_tdata),
    .cfg       (cfg_r),
    .out_valid (out_tvalid),
    .out_rgba  (rgba)
  );

endmodule

### rtl/hcr_checker.sv
// ----------------------------------------------------------------------------
// hcr_checker
// Port-level checks on the colour ramp handshakes and config port.
// ----------------------------------------------------------------------------
module hcr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tready,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [31:0]   out_tdata,
  input logic          cfg_pready
);

  // a held result keeps its data until the transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("config port not ready");

endmodule

bind height_colour_ramp_top hcr_checker u_hcr_checker (.*);

### verif/tb_height_colour_ramp_top.sv
// ----------------------------------------------------------------------------
// Height colour ramp testbench
// Streams heights through the colour ramp under several register settings,
// predicts each RGBA result in the testbench and compares in order, with
// random bursts on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_height_colour_ramp_top;
  import hcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_W = 64'sd1 <<< WF;
  localparam longint WMAX = ONE_W * 256;
  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  height_colour_ramp_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the registers for the colour predictor
  cfg_t shadow_cfg;

  logic [31:0] height_queue[$];
  logic [31:0] colour_queue[$];
  int mismatches = 0;
  int colours_seen = 0;
  longint cycle_count = 0;
  bit hold_input = 1'b0;

  function automatic longint sext(logic [31:0] x);
    return longint'(signed'(x));
  endfunction

  function automatic longint frac_quot(longint a, longint b);
    longint r, q;
    r = a;
    q = 0;
    for (int i = 0; i < WF; i++) begin
      r = r <<< 1;
      q = q <<< 1;
      if (r >= b) begin
        r -= b;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint split_ratio(longint num, longint den);
    bit neg;
    longint a, b, q0, q;
    neg = (num < 0) != (den < 0);
    a = num < 0 ? -num : num;
    b = den < 0 ? -den : den;
    q0 = a / b;
    if (q0 >= 256) q = WMAX;
    else q = (q0 <<< WF) | frac_quot(a % b, b);
    if (q > WMAX) q = WMAX;
    return neg ? -q : q;
  endfunction

  function automatic int chan_scale(int c, longint w);
    longint p;
    if (w > WMAX) w = WMAX;
    if (w <= 0) return 0;
    p = (longint'(c) * w + ONE_W / 2) >>> WF;
    return p > 255 ? 255 : int'(p);
  endfunction

  // Weighted sum of two colours; channels index 0=red..3=alpha
  function automatic logic [31:0] mix(logic [7:0] a[4], longint wa,
                                      logic [7:0] b[4], longint wb);
    logic [31:0] res;
    int s;
    res = '0;
    for (int k = 0; k < 4; k++) begin
      s = chan_scale(int'(a[k]), wa) + chan_scale(int'(b[k]), wb);
      res[8*k +: 8] = s > 255 ? 8'd255 : s[7:0];
    end
    return res;
  endfunction

  function automatic longint sq_weight(longint q);
    longint u;
    u = q - ONE_W / 2;
    return longint'(unsigned'(u * u) >> (WF - 2));
  endfunction

  function automatic logic [31:0] predict_colour(logic [31:0] zin);
    logic [7:0] lo[4], hi[4], av[4];
    longint z, from, to, d, n, v, s, m, zz, r, t, w;
    z = sext(zin);
    from = sext(shadow_cfg.range_from);
    to = sext(shadow_cfg.range_to);
    for (int k = 0; k < 4; k++) begin
      lo[k] = shadow_cfg.low_colour[24-8*k +: 8];
      hi[k] = shadow_cfg.high_colour[24-8*k +: 8];
      av[k] = lo[k] / 2 + hi[k] / 2;
    end
    if (!shadow_cfg.ramp_mode[0]) begin
      d = to - from;
      n = z - from;
      if (d < 0) begin
        d = -d;
        n = -n;
      end
      if (d == 0 || n <= 0) v = 0;
      else if (n >= d) v = ONE_W;
      else v = frac_quot(n, d);
      return mix(lo, v, hi, ONE_W - v);
    end
    s = from + to;
    v = 0;
    m = 0;
    if (s != 0) begin
      zz = z;
      m = split_ratio(from, s);
      if (s < 0) begin
        s = -s;
        zz = -zz;
      end
      r = zz % s;
      if (r < 0) r += s;
      v = frac_quot(r, s);
    end
    if (shadow_cfg.ramp_mode[2]) begin
      if (v < m) return mix(lo, ONE_W, hi, 0);
      return mix(lo, 0, hi, ONE_W);
    end
    if (shadow_cfg.ramp_mode[1]) begin
      if (2 * v < m) return mix(av, ONE_W - v, lo, v);
      if (2 * v < ONE_W + m) begin
        t = (2 * v - m) >>> 1;
        return mix(lo, ONE_W - t, hi, t);
      end
      t = (2 * v - ONE_W - m) >>> 1;
      return mix(hi, ONE_W - t, av, t);
    end
    if (v < m) begin
      w = sq_weight(frac_quot(v, m));
      return mix(lo, ONE_W - w, av, w);
    end
    w = sq_weight(frac_quot(v - m, ONE_W - m));
    return mix(av, w, hi, ONE_W - w);
  endfunction

  // Driver: bursts of transfers with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        colour_queue.push_back(predict_colour(in_tdata));
        void'(height_queue.pop_front());
      end
      if ((!in_tvalid || in_tready) && !hold_input) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (height_queue.size() > 0) begin
          // the accepted height is already popped, so the next one is at the head
          in_tvalid <= 1'b1;
          in_tdata <= height_queue[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end else if (in_tvalid && in_tready) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor and output stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    logic [31:0] exp_c;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      stall_phase <= stall_phase + 1;
      out_tready <= (stall_phase % 64 < 24) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (out_tvalid && out_tready) begin
        colours_seen <= colours_seen + 1;
        if (colour_queue.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected colour %h", out_tdata);
        end else begin
          exp_c = colour_queue.pop_front();
          if (exp_c !== out_tdata) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("colour mismatch: exp r%h g%h b%h a%h got r%h g%h b%h a%h",
                       exp_c[7:0], exp_c[15:8], exp_c[23:16], exp_c[31:24],
                       out_tdata[7:0], out_tdata[15:8], out_tdata[23:16],
                       out_tdata[31:24]);
          end
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (height_queue.size() != 0 || in_tvalid || colour_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= AW'(idx) << 2;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_FROM: shadow_cfg.range_from = val;
      REG_TO:   shadow_cfg.range_to = val;
      REG_LOW:  shadow_cfg.low_colour = val;
      REG_HIGH: shadow_cfg.high_colour = val;
      REG_MODE: shadow_cfg.ramp_mode = val[2:0];
      default: begin
      end
    endcase
  endtask

  task automatic load_ramp(logic [31:0] f, logic [31:0] t, logic [31:0] lo,
                           logic [31:0] hi, logic [2:0] md);
    apb_write(REG_FROM, f);
    apb_write(REG_TO, t);
    apb_write(REG_LOW, lo);
    apb_write(REG_HIGH, hi);
    apb_write(REG_MODE, {29'b0, md});
  endtask

  // Heights mostly near the configured span, some anywhere
  function automatic logic [31:0] pick_height();
    longint base, span;
    base = sext(shadow_cfg.range_from);
    span = sext(shadow_cfg.range_to) - base;
    if (span < 0) span = -span;
    if (span > 64'sh1_0000_0000) span = 64'sh1_0000_0000;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'(base - span + longint'($urandom) % (3 * span + 3));
    endcase
  endfunction

  initial begin
    int total;
    logic [31:0] corner_h[9];
    logic [31:0] probe_h[5];
    corner_h = '{32'h0, 32'h8000, 32'h10000, 32'h20000, 32'hFFFF8000,
                 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'hFFFFFFFF};
    probe_h = '{32'h0, 32'h4000, 32'h10000, 32'h28000, 32'hFFFFC000};
    shadow_cfg = '{RST_FROM, RST_TO, RST_LOW, RST_HIGH, RST_MODE};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: defaults, field extremes, zero span, zero period, all modes
    foreach (corner_h[i]) height_queue.push_back(corner_h[i]);
    wait_drained();
    load_ramp(32'h30000, 32'h30000, 32'h12345678, 32'h9ABCDEF0, 3'd0);
    height_queue.push_back(32'h30000);
    height_queue.push_back(32'h0);
    wait_drained();
    load_ramp(32'h10000, 32'hFFFF0000, 32'hFFFFFFFF, 32'h00000000, 3'd3);
    height_queue.push_back(32'h5555);
    height_queue.push_back(32'h80000000);
    wait_drained();
    for (int md = 1; md < 8; md += 2) begin
      load_ramp(32'h10000, 32'h30000, 32'hFF8000FF, 32'h00FF80FF, 3'(md));
      foreach (probe_h[i]) height_queue.push_back(probe_h[i]);
      wait_drained();
    end
    // Random phases: each with a fresh setting, extremes now and then
    total = 0;
    while (total < 500) begin
      int n;
      case ($urandom_range(0, 5))
        0: load_ramp($urandom, $urandom, $urandom, $urandom,
                     3'($urandom_range(0, 7)));
        1: load_ramp(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0,
                     3'($urandom_range(0, 7)));
        default: load_ramp($urandom_range(0, 32'h80000) - 32'h20000,
                           $urandom_range(0, 32'h80000) - 32'h20000,
                           $urandom, $urandom, 3'($urandom_range(0, 7)));
      endcase
      n = $urandom_range(20, 80);
      for (int i = 0; i < n; i++) height_queue.push_back(pick_height());
      total += n;
      if (total > 250 && total < 340) begin
        // Pause input until the pipeline has emptied, then go on
        wait (height_queue.size() < 10);
        hold_input = 1'b1;
        while (colour_queue.size() != 0 || in_tvalid) @(posedge clk);
        hold_input = 1'b0;
      end
      wait_drained();
    end
    $display("Covered %0d colours over cyclic, linear, quadratic, sharp modes",
             colours_seen);
    $display("with random input bursts and output stalls.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hcr_pkg.sv
rtl/hcr_core.sv
rtl/height_colour_ramp_top.sv
rtl/hcr_checker.sv
verif/tb_height_colour_ramp_top.sv
